// ===== sv/leb_pkg.sv =====
package leb_pkg;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [1:0] KIND_CONT     = 2'd0;
   localparam logic [1:0] KIND_FINAL    = 2'd1;
   localparam logic [1:0] KIND_TOO_LONG = 2'd2;
   localparam logic [1:0] KIND_TRUNC    = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_TOO_LONG = 2'd1;
   localparam logic [1:0] STATUS_TRUNC    = 2'd2;

   localparam logic [3:0] MAX_BYTES      = 4'd10;
   localparam logic [3:0] SEXT_MAX_COUNT = 4'd9;
   localparam logic [6:0] BITS_PER_BYTE  = 7'd7;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] count;
      logic [6:0] payload;
      logic       sign_ext;
   } leb_item_type;

endpackage

// ===== sv/leb128_stream_decoder_unit.sv =====
// A byte that ends a value is written into the queue and then into the output register.
// Throughput: one byte per cycle while the queue is not full; the four-entry queue
// and the output register let the input keep flowing while a result waits on rsp_ready.
// Continuation bytes produce no result and never wait on the output register.
// Reset clears the byte counter, the accumulator, the queue pointers and rsp_valid.
module leb128_stream_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_mode,
   input  logic        req_end_of_buffer,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_value,
   output logic [3:0]  rsp_byte_count,
   output logic [1:0]  rsp_status
);
   import leb_pkg::*;

   logic         queue_full;
   logic         push;
   leb_item_type push_item;
   logic         pop;
   logic         item_valid;
   leb_item_type head_item;

   leb_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_mode          (req_mode),
      .req_end_of_buffer (req_end_of_buffer),
      .queue_full        (queue_full),
      .push              (push),
      .push_item         (push_item)
   );

   leb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .item_valid (item_valid),
      .head_item  (head_item)
   );

   leb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (item_valid),
      .head_item      (head_item),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_value      (rsp_value),
      .rsp_byte_count (rsp_byte_count),
      .rsp_status     (rsp_status)
   );

endmodule

// ===== sv/leb_front.sv =====
module leb_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_mode,
   input  logic                 req_end_of_buffer,
   input  logic                 queue_full,
   output logic                 push,
   output leb_pkg::leb_item_type push_item
);
   import leb_pkg::*;

   logic [3:0] count_ff;
   logic [3:0] count_in;
   logic [3:0] count_next;

   always_comb begin
      count_next         = count_ff + 4'd1;
      push_item.payload  = req_data_byte[6:0];
      push_item.count    = count_next;
      push_item.sign_ext = req_mode & req_data_byte[6] & (count_next <= SEXT_MAX_COUNT);
      if (count_ff >= MAX_BYTES) begin
         push_item.kind  = KIND_TOO_LONG;
         push_item.count = MAX_BYTES + 4'd1;
      end else if (req_data_byte[7] && req_end_of_buffer) begin
         push_item.kind = KIND_TRUNC;
      end else if (req_data_byte[7]) begin
         push_item.kind = KIND_CONT;
      end else begin
         push_item.kind = KIND_FINAL;
      end
   end

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      count_in = count_ff;
      if (push) begin
         count_in = (push_item.kind == KIND_CONT) ? count_next : 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 4'd0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ===== sv/leb_queue.sv =====
module leb_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  leb_pkg::leb_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  item_valid,
   output leb_pkg::leb_item_type head_item
);
   import leb_pkg::*;

   leb_item_type          entries_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff;
   logic [FIFO_PTR_W-1:0] wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff;
   logic [FIFO_PTR_W-1:0] rd_ptr_in;
   logic [FIFO_LVL_W-1:0] level_ff;
   logic [FIFO_LVL_W-1:0] level_in;
   logic                  do_pop;

   assign full       = (level_ff == FIFO_LVL_W'(FIFO_DEPTH));
   assign item_valid = (level_ff != '0);
   assign head_item  = entries_ff[rd_ptr_ff];
   assign do_pop     = pop && item_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      level_in  = level_ff;
      if (push && !do_pop) begin
         level_in = level_ff + FIFO_LVL_W'(1);
      end else if (do_pop && !push) begin
         level_in = level_ff - FIFO_LVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

`ifndef SYNTH
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= FIFO_LVL_W'(FIFO_DEPTH))
      else $error("queue level exceeds depth");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into a full queue");
   a_ptr_level: assert property (@(posedge clock) disable iff (reset)
      (level_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with unequal pointers");
`endif

endmodule

// ===== sv/leb_back.sv =====
module leb_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  leb_pkg::leb_item_type head_item,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [63:0]           rsp_value,
   output logic [3:0]            rsp_byte_count,
   output logic [1:0]            rsp_status
);
   import leb_pkg::*;

   logic [63:0] acc_ff;
   logic [63:0] acc_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [63:0] value_ff;
   logic [63:0] value_in;
   logic [3:0]  count_ff;
   logic [3:0]  count_in;
   logic [1:0]  status_ff;
   logic [1:0]  status_in;
   logic        out_free;
   logic [3:0]  index;
   logic [6:0]  shamt_full;
   logic [6:0] ext_full;
   logic [63:0] merged;
   logic [63:0] ext_mask;
   logic        finishing;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop       = item_valid && ((head_item.kind == KIND_CONT) || out_free);
   assign finishing = pop && (head_item.kind != KIND_CONT);

   always_comb begin
      index      = head_item.count - 4'd1;
      shamt_full = {index, 3'b000} - {3'b000, index};
      ext_full   = shamt_full + BITS_PER_BYTE;
      merged     = acc_ff | ({57'd0, head_item.payload} << shamt_full[5:0]);
      ext_mask   = head_item.sign_ext ? (~64'd0 << ext_full[5:0]) : 64'd0;
   end

   always_comb begin
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      value_in     = value_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      if (pop) begin
         acc_in = (head_item.kind == KIND_CONT) ? merged : 64'd0;
      end
      if (finishing) begin
         rsp_valid_in = 1'b1;
         count_in     = head_item.count;
         case (head_item.kind)
            KIND_FINAL: begin
               value_in  = merged | ext_mask;
               status_in = STATUS_OK;
            end
            KIND_TOO_LONG: begin
               value_in  = 64'd0;
               status_in = STATUS_TOO_LONG;
            end
            default: begin
               value_in  = 64'd0;
               status_in = STATUS_TRUNC;
            end
         endcase
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= 64'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      count_ff  <= count_in;
      status_ff <= status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = value_ff;
   assign rsp_byte_count = count_ff;
   assign rsp_status     = status_ff;

`ifndef SYNTH
   a_too_long_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff == STATUS_TOO_LONG)) |-> (count_ff == MAX_BYTES + 4'd1))
      else $error("too-long result with wrong byte count");
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff != STATUS_OK)) |-> (value_ff == 64'd0))
      else $error("error result with nonzero value");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((count_ff != 4'd0) && (count_ff <= MAX_BYTES + 4'd1)))
      else $error("result byte count out of range");
   a_acc_clear: assert property (@(posedge clock) disable iff (reset)
      finishing |=> (acc_ff == 64'd0))
      else $error("accumulator not cleared after a result");
`endif

endmodule

// ===== tb/tb_leb128_stream_decoder_unit.sv =====
`timescale 1ns / 1ps

module tb_leb128_stream_decoder_unit;
   import leb_pkg::*;

   localparam int RANDOM_ITEMS = 1800;
   localparam int QUIET_ITEMS = 250;
   localparam int HOLD_AFTER = 500;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 10;
   localparam int RUN_LIMIT_NS = 5_000_000;
   localparam int DIRECTED_ROWS = 26;

   typedef struct packed {
      logic [63:0] value;
      logic [3:0]  byte_count;
      logic [1:0]  status;
   } leb_result_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        mode;
      logic        end_of_buffer;
      logic        typed;
      logic [63:0] value;
      logic [3:0]  byte_count;
      logic [1:0]  status;
   } directed_row_type;

   typedef enum int {SEQ_FINAL, SEQ_TRUNC, SEQ_LONG, SEQ_NOISE} seq_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_mode = 1'b0;
   logic        req_end_of_buffer = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_value;
   logic [3:0]  rsp_byte_count;
   logic [1:0]  rsp_status;

   leb_result_type pending_results[$];
   int unsigned mismatch_count = 0;

   logic [63:0] partial_value = '0;
   logic [3:0]  taken_bytes = '0;

   bit quiet_phase = 1'b0;
   bit hold_request = 1'b0;
   bit hold_active = 1'b0;
   bit hold_done = 1'b0;
   int unsigned hold_cycles = 0;
   int unsigned ready_gap = 0;
   int unsigned ready_run = 0;
   int unsigned send_run = 0;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{8'h00, 1'b0, 1'b0, 1'b1, 64'h0000_0000_0000_0000, 4'd1, STATUS_OK},
      '{8'h7F, 1'b0, 1'b0, 1'b1, 64'h0000_0000_0000_007F, 4'd1, STATUS_OK},
      '{8'h7F, 1'b1, 1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd1, STATUS_OK},
      '{8'h40, 1'b1, 1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFC0, 4'd1, STATUS_OK},
      '{8'h80, 1'b0, 1'b1, 1'b1, 64'h0, 4'd1, STATUS_TRUNC},
      '{8'hFF, 1'b0, 1'b0, 1'b0, 64'h0, 4'd0, STATUS_OK},
      '{8'hFF, 1'b0, 1'b0, 1'b0, 64'h0, 4'd0, STATUS_OK},
      '{8'hFF, 1'b0, 1'b0, 1'b0, 64'h0, 4'd0, STATUS_OK},
      '{8'hFF, 1'b0, 1'b0, 1'b0, 64'h0, 4'd0, STATUS_OK},
      '{8'hFF, 1'b0, 1'b0, 1'b0, 64'h0, 4'd0, STATUS_OK},
      '{8'hFF, 1'b0, 1'b0, 1'b0, 64'h0, 4'd0, STATUS_OK},
      '{8'hFF, 1'b0, 1'b0, 1'b0, 64'h0, 4'd0, STATUS_OK},
      '{8'hFF, 1'b0, 1'b0, 1'b0, 64'h0, 4'd0, STATUS_OK},
      '{8'hFF, 1'b0, 1'b0, 1'b0, 64'h0, 4'd0, STATUS_OK},
      '{8'h40, 1'b1, 1'b1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 4'd10, STATUS_OK},
      '{8'h80, 1'b1, 1'b0, 1'b0, 64'h0, 4'd0, STATUS_OK},
      '{8'h80, 1'b1, 1'b0, 1'b0, 64'h0, 4'd0, STATUS_OK},
      '{8'h80, 1'b1, 1'b0, 1'b0, 64'h0, 4'd0, STATUS_OK},
      '{8'h80, 1'b1, 1'b0, 1'b0, 64'h0, 4'd0, STATUS_OK},
      '{8'h80, 1'b1, 1'b0, 1'b0, 64'h0, 4'd0, STATUS_OK},
      '{8'h80, 1'b1, 1'b0, 1'b0, 64'h0, 4'd0, STATUS_OK},
      '{8'h80, 1'b1, 1'b0, 1'b0, 64'h0, 4'd0, STATUS_OK},
      '{8'h80, 1'b1, 1'b0, 1'b0, 64'h0, 4'd0, STATUS_OK},
      '{8'h80, 1'b1, 1'b0, 1'b0, 64'h0, 4'd0, STATUS_OK},
      '{8'h80, 1'b1, 1'b0, 1'b0, 64'h0, 4'd0, STATUS_OK},
      '{8'hFF, 1'b1, 1'b1, 1'b1, 64'h0, 4'd11, STATUS_TOO_LONG}
   };

   leb128_stream_decoder_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_mode          (req_mode),
      .req_end_of_buffer (req_end_of_buffer),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_value         (rsp_value),
      .rsp_byte_count    (rsp_byte_count),
      .rsp_status        (rsp_status)
   );

   always #6 clock = ~clock;

   function automatic bit decode_byte(input logic [7:0] data_byte, input logic mode,
                                      input logic end_of_buffer, output leb_result_type res);
      int unsigned shift;
      logic [3:0]  count;
      bit          done;
      res = '0;
      done = 1'b0;
      if (taken_bytes >= MAX_BYTES) begin
         res.byte_count = MAX_BYTES + 4'd1;
         res.status = STATUS_TOO_LONG;
         done = 1'b1;
      end else begin
         shift = taken_bytes * BITS_PER_BYTE;
         partial_value = partial_value | (64'(data_byte[6:0]) << shift);
         count = taken_bytes + 4'd1;
         if (data_byte[7]) begin
            if (end_of_buffer) begin
               res.byte_count = count;
               res.status = STATUS_TRUNC;
               done = 1'b1;
            end else begin
               taken_bytes = count;
            end
         end else begin
            shift = shift + BITS_PER_BYTE;
            if (mode && shift < 64 && data_byte[6]) begin
               partial_value = partial_value | (~64'd0 << shift);
            end
            res.value = partial_value;
            res.byte_count = count;
            res.status = STATUS_OK;
            done = 1'b1;
         end
      end
      if (done) begin
         partial_value = '0;
         taken_bytes = '0;
      end
      return done;
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_byte(input logic [7:0] data_byte, input logic mode,
                            input logic end_of_buffer, input bit typed,
                            input leb_result_type typed_result);
      leb_result_type res;
      bit          has_result;
      if (!quiet_phase && !(hold_request && !hold_done)) begin
         if (send_run != 0) begin
            send_run--;
         end else if ($urandom_range(0, 4) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
            send_run = $urandom_range(0, 30);
         end
      end
      req_valid <= 1'b1;
      req_data_byte <= data_byte;
      req_mode <= mode;
      req_end_of_buffer <= end_of_buffer;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      has_result = decode_byte(data_byte, mode, end_of_buffer, res);
      if (typed) begin
         pending_results.push_back(typed_result);
      end else if (has_result) begin
         pending_results.push_back(res);
      end
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (hold_active) begin
         if (hold_cycles == 0) begin
            hold_active <= 1'b0;
            hold_done <= 1'b1;
            rsp_ready <= 1'b1;
         end else begin
            hold_cycles <= hold_cycles - 1;
         end
      end else if (hold_request && !hold_done) begin
         hold_active <= 1'b1;
         hold_cycles <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (quiet_phase) begin
         rsp_ready <= 1'b1;
      end else if (ready_gap != 0) begin
         ready_gap <= ready_gap - 1;
         if (ready_gap == 1) begin
            rsp_ready <= 1'b1;
            ready_run <= $urandom_range(0, 50);
         end
      end else if (ready_run != 0) begin
         ready_run <= ready_run - 1;
         rsp_ready <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         ready_gap <= $urandom_range(1, 18);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      leb_result_type got;
      leb_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_value, rsp_byte_count, rsp_status};
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected transfer: value %h count %0d code %0d",
                        got.value, got.byte_count, got.status);
            end
         end else begin
            want = pending_results.pop_front();
            if (got.value !== want.value || got.byte_count !== want.byte_count ||
                got.status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: expected %h/%0d/%0d, got %h/%0d/%0d",
                           want.value, want.byte_count, want.status,
                           got.value, got.byte_count, got.status);
               end
            end
         end
      end
   end

   initial begin
      int             sent_random;
      int             seq_len;
      int             shape;
      int             waited;
      seq_kind_type   seq_kind;
      logic [7:0]     data_byte;
      logic           end_of_buffer;
      bit             last;
      leb_result_type typed_result;
      sent_random = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         typed_result = '{directed_rows[i].value, directed_rows[i].byte_count,
                          directed_rows[i].status};
         send_byte(directed_rows[i].data_byte, directed_rows[i].mode,
                   directed_rows[i].end_of_buffer, directed_rows[i].typed, typed_result);
      end

      while (sent_random < RANDOM_ITEMS) begin
         quiet_phase = (sent_random >= RANDOM_ITEMS - QUIET_ITEMS);
         if (!hold_request && sent_random >= HOLD_AFTER) hold_request = 1'b1;
         shape = $urandom_range(0, 99);
         if (shape < 70) begin
            seq_kind = SEQ_FINAL;
            seq_len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 4);
         end else if (shape < 82) begin
            seq_kind = SEQ_TRUNC;
            seq_len = $urandom_range(1, 10);
         end else if (shape < 90) begin
            seq_kind = SEQ_LONG;
            seq_len = 11;
         end else begin
            seq_kind = SEQ_NOISE;
            seq_len = $urandom_range(1, 6);
         end
         for (int k = 0; k < seq_len; k++) begin
            last = (k == seq_len - 1);
            data_byte = 8'($urandom);
            end_of_buffer = 1'b0;
            case (seq_kind)
               SEQ_FINAL: begin
                  data_byte[7] = !last;
                  end_of_buffer = last & 1'($urandom);
               end
               SEQ_TRUNC: begin
                  data_byte[7] = 1'b1;
                  end_of_buffer = last;
               end
               SEQ_LONG: begin
                  if (!last) data_byte[7] = 1'b1;
                  else end_of_buffer = 1'($urandom);
               end
               default: begin
                  end_of_buffer = ($urandom_range(0, 3) == 0);
               end
            endcase
            send_byte(data_byte, 1'($urandom), end_of_buffer, 1'b0, '0);
            sent_random++;
         end
      end
      req_valid <= 1'b0;

      waited = 0;
      while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         mismatch_count++;
         $display("%0d expected transfers never arrived", pending_results.size());
      end
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("status: fail");
      $finish;
   end

endmodule
